// ===== sv/dbsd_pkg.sv =====
// Shared types and constants for the dead-block replacement engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dbsd_pkg;

  localparam int NumSets     = 2048;
  localparam int SetW        = $clog2(NumSets);
  localparam int NumWays     = 16;
  localparam int WayW        = $clog2(NumWays);
  localparam int LeaderSets  = 64;
  localparam int DecayPeriod = 4096;
  localparam int AccW        = $clog2(DecayPeriod);
  localparam int SigBits     = 6;
  localparam int NumSigs     = 1 << SigBits;
  localparam int DuelW       = 10;
  localparam int PcW         = 64;
  localparam int CntW        = 2;
  localparam int BipBits     = 5;

  localparam logic [DuelW-1:0] DuelMid   = DuelW'(511);
  localparam logic [15:0]      LfsrSeed  = 16'hACE1;
  localparam logic [CntW-1:0]  CntMax    = CntW'(3);
  localparam logic [CntW-1:0]  CntReset  = CntW'(1);
  localparam logic [CntW-1:0]  HotLevel  = CntW'(2);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DECAY, ST_ROW, ST_VIC, ST_OLD, ST_DEC, ST_NEW, ST_FIN
  } dbsd_state_e;

  typedef struct packed {
    logic load;         // capture an input beat
    logic sweep_init;   // reset pass: reuse all one, signatures zero
    logic sweep_decay;  // decay pass: reuse all zero
    logic row_rd;       // read set rows
    logic cnt_rd_old;   // read counter of victim's stored signature
    logic cnt_dec;      // conditional decrement of that counter
    logic cnt_rd_new;   // read counter of the new signature
    logic fin;          // write back rows, drive update result
    logic vic;          // drive victim result
  } dbsd_cmd_t;

  typedef struct packed {
    logic decay_due;    // next update beat completes a decay period
    logic sweep_last;
    logic is_update;
    logic is_hit;
  } dbsd_stat_t;

endpackage
`default_nettype wire

// ===== sv/dbsd_ctrl.sv =====
// Sequencer for the replacement engine.
// Depends on dbsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbsd_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  wire                       cmd_i,
  input  wire dbsd_pkg::dbsd_stat_t stat_i,
  output dbsd_pkg::dbsd_cmd_t       ctl_o,
  output logic                      busy_o
);
  import dbsd_pkg::*;

  dbsd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:  if (stat_i.sweep_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (start_i) begin
          state_d = (cmd_i && stat_i.decay_due) ? ST_DECAY : ST_ROW;
        end
      end
      ST_DECAY: if (stat_i.sweep_last) state_d = ST_ROW;
      ST_ROW: begin
        if (!stat_i.is_update)  state_d = ST_VIC;
        else if (stat_i.is_hit) state_d = ST_NEW;
        else                    state_d = ST_OLD;
      end
      ST_VIC:  state_d = ST_IDLE;
      ST_OLD:  state_d = ST_DEC;
      ST_DEC:  state_d = ST_NEW;
      ST_NEW:  state_d = ST_FIN;
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_INIT:  ctl_o.sweep_init = 1'b1;
      ST_IDLE: begin
        busy_o     = 1'b0;
        ctl_o.load = start_i;
      end
      ST_DECAY: ctl_o.sweep_decay = 1'b1;
      ST_ROW:   ctl_o.row_rd = 1'b1;
      ST_VIC:   ctl_o.vic = 1'b1;
      ST_OLD:   ctl_o.cnt_rd_old = 1'b1;
      ST_DEC:   ctl_o.cnt_dec = 1'b1;
      ST_NEW:   ctl_o.cnt_rd_new = 1'b1;
      ST_FIN:   ctl_o.fin = 1'b1;
      default:  busy_o = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/dbsd_dp.sv =====
// Datapath: set row memories, signature counter memory, LFSR, access count.
// Depends on dbsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbsd_dp (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire dbsd_pkg::dbsd_cmd_t         ctl_i,
  output dbsd_pkg::dbsd_stat_t             stat_o,
  input  wire                              duel_counter_we_i,
  input  wire  [dbsd_pkg::DuelW-1:0]       duel_counter_i,
  input  wire                              cmd_i,
  input  wire  [dbsd_pkg::SetW-1:0]        set_index_i,
  input  wire  [dbsd_pkg::WayW-1:0]        way_index_i,
  input  wire  [dbsd_pkg::PcW-1:0]         pc_i,
  input  wire                              hit_i,
  output logic                             done_o,
  output logic [dbsd_pkg::WayW-1:0]        victim_way_o,
  output logic                             inserted_live_o
);
  import dbsd_pkg::*;

  localparam int RowSigW = NumWays * SigBits;

  logic [NumWays-1:0] reuse_mem [NumSets];
  logic [RowSigW-1:0] sig_mem   [NumSets];
  logic [CntW-1:0]    cnt_mem   [NumSigs];

  logic [NumSigs-1:0] cnt_vld_q;
  logic [DuelW-1:0]   duel_q;
  logic [AccW-1:0]    acc_q;
  logic [15:0]        lfsr_q, lfsr_d;
  logic [SetW-1:0]    sweep_q;

  logic               cmd_q, hit_q;
  logic [SetW-1:0]    set_q;
  logic [WayW-1:0]    way_q;
  logic [SigBits-1:0] sig_q;

  logic [NumWays-1:0] reuse_rd_q;
  logic [RowSigW-1:0] sig_rd_q;
  logic [CntW-1:0]    cnt_rd_q;
  logic               cnt_rvld_q;

  logic [CntW-1:0]    cnt_val;
  logic [SigBits-1:0] old_sig;
  logic [SigBits-1:0] cnt_raddr;
  logic               cnt_rd;
  logic               cnt_we;
  logic [SigBits-1:0] cnt_waddr;
  logic [CntW-1:0]    cnt_wdata;
  logic [WayW-1:0]    vic_way;
  logic               use_bip;
  logic               live;
  logic               reuse_we, sig_we;
  logic [SetW-1:0]    row_waddr;
  logic [NumWays-1:0] reuse_wdata;
  logic [RowSigW-1:0] sig_wdata;

  assign stat_o.decay_due  = (acc_q == AccW'(DecayPeriod - 1));
  assign stat_o.sweep_last = (sweep_q == SetW'(NumSets - 1));
  assign stat_o.is_update  = cmd_q;
  assign stat_o.is_hit     = hit_q;

  assign cnt_val = cnt_rvld_q ? cnt_rd_q : CntReset;
  assign old_sig = sig_rd_q[way_q*SigBits +: SigBits];

  always_comb begin
    vic_way = '0;
    for (int w = NumWays - 1; w >= 0; w--) begin
      if (!reuse_rd_q[w]) vic_way = WayW'(w);
    end
  end

  assign use_bip = (set_q >= SetW'(NumSets - LeaderSets)) ||
                   ((set_q >= SetW'(LeaderSets)) && (duel_q < DuelMid));

  assign lfsr_d = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};

  always_comb begin
    if (hit_q)                  live = 1'b1;
    else if (cnt_val >= HotLevel) live = 1'b1;
    else if (use_bip)           live = (lfsr_d[BipBits-1:0] == '0);
    else                        live = 1'b0;
  end

  // counter memory port control
  assign cnt_rd    = ctl_i.cnt_rd_old | ctl_i.cnt_rd_new;
  assign cnt_raddr = ctl_i.cnt_rd_old ? old_sig : sig_q;
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = sig_q;
    cnt_wdata = cnt_val;
    if (ctl_i.cnt_dec) begin
      cnt_waddr = old_sig;
      cnt_wdata = cnt_val - CntW'(1);
      cnt_we    = !reuse_rd_q[way_q] && (cnt_val != '0);
    end else if (ctl_i.fin && hit_q) begin
      cnt_wdata = (cnt_val == CntMax) ? cnt_val : cnt_val + CntW'(1);
      cnt_we    = 1'b1;
    end
  end

  // row write port control
  always_comb begin
    row_waddr   = set_q;
    reuse_we    = 1'b0;
    sig_we      = 1'b0;
    reuse_wdata = reuse_rd_q;
    sig_wdata   = sig_rd_q;
    if (ctl_i.sweep_init || ctl_i.sweep_decay) begin
      row_waddr   = sweep_q;
      reuse_we    = 1'b1;
      sig_we      = ctl_i.sweep_init;
      reuse_wdata = {NumWays{ctl_i.sweep_init}};
      sig_wdata   = '0;
    end else if (ctl_i.fin) begin
      reuse_we               = 1'b1;
      sig_we                 = !hit_q;
      reuse_wdata[way_q]     = live;
      sig_wdata[way_q*SigBits +: SigBits] = sig_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (reuse_we) reuse_mem[row_waddr] <= reuse_wdata;
    if (sig_we)   sig_mem[row_waddr]   <= sig_wdata;
    if (ctl_i.row_rd) begin
      reuse_rd_q <= reuse_mem[set_q];
      sig_rd_q   <= sig_mem[set_q];
    end
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_rd) cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i;
      hit_q <= hit_i;
      set_q <= set_index_i;
      way_q <= way_index_i;
      sig_q <= pc_i[2 +: SigBits] ^ pc_i[8 +: SigBits];
    end
    if (ctl_i.vic || ctl_i.fin) begin
      victim_way_o    <= ctl_i.vic ? vic_way : '0;
      inserted_live_o <= ctl_i.fin ? live : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q  <= '0;
      cnt_rvld_q <= 1'b0;
      duel_q     <= DuelMid;
      acc_q      <= '0;
      lfsr_q     <= LfsrSeed;
      sweep_q    <= '0;
      done_o     <= 1'b0;
    end else begin
      done_o <= ctl_i.vic | ctl_i.fin;
      if (duel_counter_we_i) duel_q <= duel_counter_i;
      if (cnt_we) cnt_vld_q[cnt_waddr] <= 1'b1;
      if (cnt_rd) cnt_rvld_q <= cnt_vld_q[cnt_raddr];
      if (ctl_i.load && cmd_i) acc_q <= acc_q + AccW'(1);  // wraps at the period
      if (ctl_i.sweep_init || ctl_i.sweep_decay) sweep_q <= sweep_q + SetW'(1);
      if (ctl_i.fin && !hit_q && (cnt_val < HotLevel) && use_bip) lfsr_q <= lfsr_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dead_block_ship_dip_replacement.sv =====
// Top level of the dead-block replacement engine: controller plus datapath.
// Depends on dbsd_pkg, dbsd_ctrl, dbsd_dp.
//
//  channel   ports                                        handshake
//  -------   -------------------------------------------  ----------------------
//  command   cmd_i set_index_i way_index_i pc_i hit_i     start_i & !busy_o
//  result    victim_way_o inserted_live_o                 done_o, one cycle
//  config    duel_counter_i                               duel_counter_we_i
//
// Victim beat: set row read, then result. Update: set row read, then counter
// memory read/modify/write; a miss first reads and may decrement the old counter.
// Every 4096th update first runs a pass over all sets clearing the reuse rows.
// After reset a pass over all sets initializes the row memories; busy_o is high.
// The receiver cannot stall; done_o marks each result for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module dead_block_ship_dip_replacement (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  output logic                        busy_o,
  input  wire                         cmd_i,
  input  wire  [dbsd_pkg::SetW-1:0]   set_index_i,
  input  wire  [dbsd_pkg::WayW-1:0]   way_index_i,
  input  wire  [dbsd_pkg::PcW-1:0]    pc_i,
  input  wire                         hit_i,
  output logic                        done_o,
  output logic [dbsd_pkg::WayW-1:0]   victim_way_o,
  output logic                        inserted_live_o,
  input  wire                         duel_counter_we_i,
  input  wire  [dbsd_pkg::DuelW-1:0]  duel_counter_i
);
  import dbsd_pkg::*;

  dbsd_cmd_t  ctl;
  dbsd_stat_t stat;

  dbsd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .ctl_o  (ctl),
    .busy_o (busy_o)
  );

  dbsd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .stat_o           (stat),
    .duel_counter_we_i(duel_counter_we_i),
    .duel_counter_i   (duel_counter_i),
    .cmd_i            (cmd_i),
    .set_index_i      (set_index_i),
    .way_index_i      (way_index_i),
    .pc_i             (pc_i),
    .hit_i            (hit_i),
    .done_o           (done_o),
    .victim_way_o     (victim_way_o),
    .inserted_live_o  (inserted_live_o)
  );

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result beat while still busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted beat not held busy");
  a_update_zero_way: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && inserted_live_o) |-> (victim_way_o == '0))
    else $error("update result carries a victim way");
  a_no_double_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("two result beats back to back");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the dead-block replacement engine: drives victim and update
// commands, predicts every result in a local model, checks each done_o beat.
// Depends on dbsd_pkg and dead_block_ship_dip_replacement.
`timescale 1ns / 1ps
module tb;
  import dbsd_pkg::*;

  localparam int NumBlocks = NumSets * NumWays;

  typedef struct packed {
    logic [WayW-1:0] victim;
    logic            live;
  } repl_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic              cmd_i = 1'b0;
  logic [SetW-1:0]   set_index_i = '0;
  logic [WayW-1:0]   way_index_i = '0;
  logic [PcW-1:0]    pc_i = '0;
  logic              hit_i = 1'b0;
  logic              done_o;
  logic [WayW-1:0]   victim_way_o;
  logic              inserted_live_o;
  logic              duel_counter_we_i = 1'b0;
  logic [DuelW-1:0]  duel_counter_i = '0;

  dead_block_ship_dip_replacement dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .set_index_i, .way_index_i,
    .pc_i, .hit_i, .done_o, .victim_way_o, .inserted_live_o,
    .duel_counter_we_i, .duel_counter_i
  );

  always #5 clk_i = ~clk_i;

  // local copy of the replacement state
  logic [SigBits-1:0] blk_sig [NumBlocks];
  logic               blk_live [NumBlocks];
  logic [CntW-1:0]    sig_cnt [NumSigs];
  logic [AccW-1:0]    acc_cnt;
  logic [15:0]        lfsr_q;
  logic [DuelW-1:0]   duel_q;

  repl_res_t expected_q[$];
  int errors = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_live = 0;
  bit quiet = 1'b0;

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= 30) $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic model_reset();
    for (int i = 0; i < NumBlocks; i++) begin
      blk_sig[i] = '0;
      blk_live[i] = 1'b1;
    end
    for (int i = 0; i < NumSigs; i++) sig_cnt[i] = CntReset;
    acc_cnt = '0;
    lfsr_q = LfsrSeed;
    duel_q = DuelMid;
  endtask

  function automatic repl_res_t predict_access(logic c, logic [SetW-1:0] s,
                                               logic [WayW-1:0] w, logic [PcW-1:0] pc,
                                               logic h);
    repl_res_t r;
    int idx;
    logic [SigBits-1:0] sg, og;
    logic fb;
    bit bip;
    r = '0;
    if (!c) begin
      for (int k = NumWays - 1; k >= 0; k--)
        if (!blk_live[s * NumWays + k]) r.victim = WayW'(k);
      return r;
    end
    idx = s * NumWays + w;
    sg = SigBits'((pc >> 2) ^ (pc >> 8));
    if (acc_cnt == AccW'(DecayPeriod - 1)) begin
      acc_cnt = '0;
      for (int i = 0; i < NumBlocks; i++) blk_live[i] = 1'b0;
    end else begin
      acc_cnt++;
    end
    if (h) begin
      blk_live[idx] = 1'b1;
      if (sig_cnt[sg] != CntMax) sig_cnt[sg]++;
      r.live = 1'b1;
    end else begin
      og = blk_sig[idx];
      if (!blk_live[idx] && sig_cnt[og] != 0) sig_cnt[og]--;
      if (sig_cnt[sg] >= HotLevel) r.live = 1'b1;
      else begin
        if (s >= NumSets - LeaderSets) bip = 1;
        else if (s < LeaderSets) bip = 0;
        else bip = duel_q < DuelMid;
        if (bip) begin
          fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
          lfsr_q = {fb, lfsr_q[15:1]};
          r.live = lfsr_q[BipBits-1:0] == '0;
        end
      end
      blk_live[idx] = r.live;
      blk_sig[idx] = sg;
    end
    return r;
  endfunction

  // result checker: receiver never stalls
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) report("unexpected result", victim_way_o, -1);
      else begin
        repl_res_t e;
        e = expected_q.pop_front();
        n_checked++;
        if (inserted_live_o) n_live++;
        if (victim_way_o !== e.victim) report("victim_way", victim_way_o, e.victim);
        if (inserted_live_o !== e.live) report("inserted_live", inserted_live_o, e.live);
      end
    end
  end

  task automatic send_access(logic c, logic [SetW-1:0] s, logic [WayW-1:0] w,
                             logic [PcW-1:0] pc, logic h);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
    // always wait on the clock after the last drive, so start_i is driven once per step
    repeat (gap + 1) @(posedge clk_i);
    start_i <= 1'b1;
    cmd_i <= c;
    set_index_i <= s;
    way_index_i <= w;
    pc_i <= pc;
    hit_i <= h;
    // busy_o only moves at the rising edge; sample it mid-cycle
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    expected_q.push_back(predict_access(c, s, w, pc, h));
    n_items++;
    start_i <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_duel(logic [DuelW-1:0] v);
    drain();
    duel_counter_we_i <= 1'b1;
    duel_counter_i <= v;
    @(posedge clk_i);
    duel_counter_we_i <= 1'b0;
    duel_q = v;
  endtask

  function automatic logic [PcW-1:0] rand_pc();
    return {$urandom(), $urandom()};
  endfunction

  // pc whose signature is sg (bits above 7 zero)
  function automatic logic [PcW-1:0] pc_for(logic [SigBits-1:0] sg);
    return PcW'({sg, 2'b00});
  endfunction

  task automatic test_directed();
    send_access(1'b0, '0, '0, '0, 1'b0);
    send_access(1'b0, '1, '1, '1, 1'b1);
    send_access(1'b1, 11'd5, 4'd3, '1, 1'b1);
    send_access(1'b1, 11'd5, 4'd4, pc_for(6'd9), 1'b0);
    send_access(1'b0, 11'd5, '0, '0, 1'b0);
    send_access(1'b1, '1, '1, pc_for(6'd9), 1'b0);
    send_access(1'b1, '1, 4'd0, '0, 1'b0);
    send_access(1'b1, 11'(NumSets - LeaderSets), 4'd2, 64'h5555_5555_5555_5555, 1'b0);
    send_access(1'b1, 11'(LeaderSets - 1), 4'd7, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    send_access(1'b1, 11'd1000, 4'd8, pc_for(6'd17), 1'b0);
    send_access(1'b0, 11'd1000, '0, '0, 1'b0);
    send_access(1'b1, 11'd1000, 4'd8, pc_for(6'd33), 1'b0);
    send_access(1'b1, 11'd1000, 4'd8, pc_for(6'd33), 1'b1);
    write_duel('0);
    send_access(1'b1, 11'd1000, 4'd9, pc_for(6'd17), 1'b0);
    send_access(1'b1, 11'd1001, 4'd9, pc_for(6'd17), 1'b0);
    write_duel(DuelW'(1023));
    send_access(1'b1, 11'd1002, 4'd9, pc_for(6'd17), 1'b0);
    write_duel(DuelW'(510));
    send_access(1'b1, 11'd1003, 4'd9, pc_for(6'd17), 1'b0);
  endtask

  // fill/hit/victim sequences; narrow mode keeps to a few hot sets so state is reused
  task automatic test_random(int count, bit narrow);
    logic [SetW-1:0] s;
    for (int i = 0; i < count; i++) begin
      if (narrow) s = SetW'($urandom_range(0, 7) * 293 + $urandom_range(0, 1) * 3);
      else s = SetW'($urandom());
      if ($urandom_range(0, 3) == 0) s = SetW'($urandom_range(NumSets - LeaderSets, NumSets - 1));
      if ($urandom_range(0, 2) == 0) send_access(1'b0, s, WayW'($urandom()), rand_pc(), 1'($urandom()));
      else send_access(1'b1, s, WayW'($urandom()),
                       $urandom_range(0, 1) ? pc_for(SigBits'($urandom_range(0, 7))) : rand_pc(),
                       $urandom_range(0, 2) == 0);
    end
  endtask

  task automatic test_hit_run();
    // long run of hits over four sets, then mixed traffic on top
    for (int i = 0; i < 500; i++)
      send_access(1'b1, SetW'($urandom_range(0, 3)), WayW'($urandom()), '0, 1'b1);
    test_random(40, 1);
  endtask

  initial begin
    model_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300, 1);
    write_duel(DuelW'(200));
    test_random(300, 1);
    write_duel(DuelMid);
    test_random(200, 0);
    write_duel(DuelW'(1023));
    quiet = 1'b1;
    test_random(300, 1);
    test_hit_run();
    drain();
    $display("covered %0d commands, %0d results checked, %0d live insertions",
             n_items, n_checked, n_live);
    $display("duel settings 0/200/510/511/1023, long hit run over four sets");
    if (errors == 0 && expected_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #30ms;
    $display("status: fail");
    $finish;
  end
endmodule
